// ----- design/a2ab_pkg.sv -----
// Shared types and constants of the length-prefixed to Annex B converter.
package a2ab_pkg;
  localparam int SizeBitsDefault = 24;
  localparam int QueueDepth = 4;

  // Work handed from the parser to the emitter.
  typedef struct packed {
    logic       start;      // emit 00 00 00 01 first
    logic       pay;        // emit data byte
    logic       fin;        // emit end status
    logic [1:0] status;
    logic [7:0] data;
  } a2ab_cmd_t;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StShort = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
endpackage

// ----- design/avcc_to_annexb_converter_core.sv -----
// Top level of the length-prefixed to Annex B converter.
// Input words are bytes of one buffer; the parser takes one every cycle while the
// queue has room, and the emitter puts out one output word per cycle while the
// receiver is ready, the first word of an input byte coming from the registered
// command queue. A unit start adds four start-code words and the last byte of a
// buffer adds one end-status word; while these go out, the parser stalls once the
// queue is full. s_tdata: data_byte[7:0],
// buffer_size[31:8]; s_tuser: is_config; s_tlast: last_byte. m_tdata: out_byte;
// m_tuser: kind[0], status[2:1]; m_tlast: run_last. Register 0 at address 0:
// hevc_record_layout.
module avcc_to_annexb_converter_core import a2ab_pkg::*; #(
  parameter int SIZE_BITS = SizeBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // data_byte[7:0], buffer_size[31:8]
  input  logic        s_tuser,   // is_config
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic [2:0]  m_tuser,   // kind[0], status[2:1]
  output logic        m_tlast    // run_last
);
  logic hevc;
  logic qv, qr, ev, er;
  a2ab_cmd_t pc, ec;

  assign pready = 1'b1;
  assign prdata = {31'd0, hevc};
  always_ff @(posedge clk) begin
    if (rst) hevc <= 1'b0;
    else if (psel && penable && pwrite && paddr == 1'b0) hevc <= pwdata[0];
  end

  a2ab_parser #(.SIZE_BITS(SIZE_BITS)) u_parser (
    .clk, .rst, .hevc, .in_valid(s_tvalid), .in_ready(s_tready),
    .data_byte(s_tdata[7:0]), .is_config(s_tuser), .buffer_size(s_tdata[31:8]),
    .last_byte(s_tlast), .cmd_valid(qv), .cmd_ready(qr), .cmd(pc));

  a2ab_queue u_queue (
    .clk, .rst, .wr_valid(qv), .wr_ready(qr), .wr_cmd(pc),
    .rd_valid(ev), .rd_ready(er), .rd_cmd(ec));

  a2ab_emitter u_emit (
    .clk, .rst, .cmd_valid(ev), .cmd_ready(er), .cmd(ec),
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast);
endmodule

// ----- design/a2ab_parser.sv -----
// Front part: parse each input byte and classify the work it causes.
module a2ab_parser import a2ab_pkg::*; #(
  parameter int SIZE_BITS = SizeBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            hevc,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      data_byte,
  input  logic            is_config,
  input  logic [23:0]     buffer_size,
  input  logic            last_byte,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output a2ab_cmd_t       cmd
);
  typedef enum logic [3:0] {
    PH_IDLE, PH_SKIP, PH_S_LEN, PH_S_PAY, PH_H_ARR, PH_H_CNT_HI, PH_H_CNT_LO,
    PH_H_NALU, PH_A_SPS, PH_A_PPS_CNT, PH_A_PPS, PH_C_LEN_HI, PH_C_LEN_LO,
    PH_C_PAY, PH_DONE, PH_SHORT
  } phase_t;

  localparam logic [SIZE_BITS-1:0] PosMax = '1;
  localparam int W = SIZE_BITS + 2;

  phase_t                phase;
  logic [SIZE_BITS-1:0]  pos;
  logic [31:0]           unit_length;
  logic [31:0]           payload_left;
  logic [1:0]            prefix_count;
  logic [7:0]            group_left;
  logic [15:0]           units_left;
  logic                  emitted_any;

  phase_t                phase_next, p;
  logic [31:0]           unit_length_next, payload_left_next;
  logic [1:0]            prefix_count_next;
  logic [7:0]            group_left_next;
  logic [15:0]           units_left_next;
  logic                  emitted_next;
  a2ab_cmd_t             c;
  logic [SIZE_BITS-1:0]  size;
  logic [W-1:0]          pw, sw;
  logic [32:0]           ul_full;
  logic [32:0]           end33;
  logic [31:0]           ul_s;
  logic [15:0]           ul_c;
  logic                  list_ok;

  assign size = SIZE_BITS'(buffer_size);
  assign in_ready = cmd_ready;
  assign cmd_valid = in_valid;
  assign cmd = c;

  always_comb begin
    p = phase;
    phase_next = phase;
    unit_length_next = unit_length;
    payload_left_next = payload_left;
    prefix_count_next = prefix_count;
    group_left_next = group_left;
    units_left_next = units_left;
    emitted_next = emitted_any;
    c = '0;
    c.data = data_byte;
    pw = W'(pos);
    sw = W'(size);
    if (phase == PH_IDLE) begin
      pw = '0;
      emitted_next = 1'b0;
      prefix_count_next = '0;
      if (!is_config) p = (size < SIZE_BITS'(4)) ? PH_SHORT : PH_S_LEN;
      else p = (size < (hevc ? SIZE_BITS'(23) : SIZE_BITS'(7))) ? PH_SHORT : PH_SKIP;
    end
    ul_s = {unit_length[23:0], data_byte};
    ul_c = {unit_length[7:0], data_byte};
    ul_full = 33'(pw) + 33'd1 + 33'(ul_s);
    end33 = 33'(pw) + 33'd1 + 33'(ul_c);
    list_ok = (units_left != 16'd0) && (pw + W'(2) <= sw);
    // One-step resolution of the pass-through list phases.
    if (p == PH_H_NALU) p = list_ok ? PH_C_LEN_HI : PH_H_ARR;
    else if (p == PH_A_SPS) p = list_ok ? PH_C_LEN_HI : PH_A_PPS_CNT;
    else if (p == PH_A_PPS) p = list_ok ? PH_C_LEN_HI : PH_DONE;
    phase_next = p;
    unique case (p)
      PH_SKIP: begin
        if (pw > W'(hevc ? 22 : 5)) phase_next = PH_DONE;
        else if (pw == W'(hevc ? 22 : 5)) begin
          if (hevc) begin
            group_left_next = data_byte;
            phase_next = PH_H_ARR;
          end else begin
            units_left_next = {11'd0, data_byte[4:0]};
            group_left_next = '0;
            phase_next = PH_A_SPS;
          end
        end
      end
      PH_S_LEN: begin
        if (prefix_count == 2'd0 && (pw + W'(4) > sw)) phase_next = PH_DONE;
        else begin
          unit_length_next = (prefix_count == 2'd0) ? {24'd0, data_byte} : ul_s;
          prefix_count_next = prefix_count + 2'd1;
          if (prefix_count == 2'd3) begin
            if (ul_s == 32'd0 || ul_full > 33'(sw)) phase_next = PH_DONE;
            else begin
              c.start = 1'b1;
              emitted_next = 1'b1;
              payload_left_next = ul_s;
              phase_next = PH_S_PAY;
            end
          end
        end
      end
      PH_S_PAY: begin
        c.pay = 1'b1;
        payload_left_next = payload_left - 32'd1;
        if (payload_left == 32'd1) begin
          phase_next = PH_S_LEN;
          prefix_count_next = '0;
        end
      end
      PH_H_ARR: begin
        if (group_left == 8'd0 || (pw + W'(3) > sw)) phase_next = PH_DONE;
        else begin
          group_left_next = group_left - 8'd1;
          phase_next = PH_H_CNT_HI;
        end
      end
      PH_H_CNT_HI: begin
        units_left_next = {data_byte, 8'd0};
        phase_next = PH_H_CNT_LO;
      end
      PH_H_CNT_LO: begin
        units_left_next = units_left | {8'd0, data_byte};
        phase_next = PH_H_NALU;
      end
      PH_A_PPS_CNT: begin
        if (pw >= sw) phase_next = PH_DONE;
        else begin
          units_left_next = {8'd0, data_byte};
          group_left_next = 8'd1;
          phase_next = PH_A_PPS;
        end
      end
      PH_C_LEN_HI: begin
        unit_length_next = {24'd0, data_byte};
        phase_next = PH_C_LEN_LO;
      end
      PH_C_LEN_LO: begin
        unit_length_next = {16'd0, ul_c};
        if (end33 > 33'(sw)) begin
          if (hevc) phase_next = PH_H_ARR;
          else phase_next = (group_left != 8'd0) ? PH_DONE : PH_A_PPS_CNT;
        end else begin
          c.start = 1'b1;
          emitted_next = 1'b1;
          units_left_next = units_left - 16'd1;
          if (ul_c == 16'd0)
            phase_next = hevc ? PH_H_NALU : ((group_left != 8'd0) ? PH_A_PPS : PH_A_SPS);
          else begin
            payload_left_next = {16'd0, ul_c};
            phase_next = PH_C_PAY;
          end
        end
      end
      PH_C_PAY: begin
        c.pay = 1'b1;
        payload_left_next = payload_left - 32'd1;
        if (payload_left == 32'd1)
          phase_next = hevc ? PH_H_NALU : ((group_left != 8'd0) ? PH_A_PPS : PH_A_SPS);
      end
      default: ;
    endcase
    if (last_byte) begin
      c.fin = 1'b1;
      c.status = (phase_next == PH_SHORT) ? StShort : (emitted_next ? StOk : StEmpty);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos <= '0;
      unit_length <= '0;
      payload_left <= '0;
      prefix_count <= '0;
      group_left <= '0;
      units_left <= '0;
      emitted_any <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (last_byte) begin
        phase <= PH_IDLE;
        pos <= '0;
        unit_length <= '0;
        payload_left <= '0;
        prefix_count <= '0;
        group_left <= '0;
        units_left <= '0;
        emitted_any <= 1'b0;
      end else begin
        phase <= phase_next;
        pos <= (pw[SIZE_BITS-1:0] < PosMax) ? pw[SIZE_BITS-1:0] + SIZE_BITS'(1) : PosMax;
        unit_length <= unit_length_next;
        payload_left <= payload_left_next;
        prefix_count <= prefix_count_next;
        group_left <= group_left_next;
        units_left <= units_left_next;
        emitted_any <= emitted_next;
      end
    end
  end
endmodule

// ----- design/a2ab_queue.sv -----
// Short command queue between parser and emitter.
module a2ab_queue import a2ab_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  a2ab_cmd_t wr_cmd,
  output logic      rd_valid,
  input  logic      rd_ready,
  output a2ab_cmd_t rd_cmd
);
  localparam int AW = $clog2(QueueDepth);
  a2ab_cmd_t mem [QueueDepth];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic wr, rd;

  assign wr_ready = (cnt != (AW+1)'(QueueDepth));
  assign rd_valid = (cnt != '0);
  assign rd_cmd = mem[rp];
  assign wr = wr_valid && wr_ready && (wr_cmd.start || wr_cmd.pay || wr_cmd.fin);
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wr_cmd;
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (wr) wp <= wp + AW'(1);
      if (rd) rp <= rp + AW'(1);
      cnt <= cnt + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end
endmodule

// ----- design/a2ab_emitter.sv -----
// Back part: expand one command into its output words.
module a2ab_emitter import a2ab_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  a2ab_cmd_t  cmd,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [2:0] m_tuser,
  output logic       m_tlast
);
  logic [2:0] step;   // 0..3 start code, 4 data, 5 status
  logic [2:0] first, fin_step;
  logic [2:0] cur;

  assign first = cmd.start ? 3'd0 : (cmd.pay ? 3'd4 : 3'd5);
  assign fin_step = cmd.fin ? 3'd5 : (cmd.pay ? 3'd4 : 3'd3);
  assign cur = (step == 3'd7) ? first : step;
  assign m_tvalid = cmd_valid;
  assign cmd_ready = m_tready && (cur == fin_step);
  assign m_tlast = (cur == fin_step);

  always_comb begin
    m_tdata = 8'd0;
    m_tuser = 3'd0;
    case (cur)
      3'd3: m_tdata = 8'h01;
      3'd4: m_tdata = cmd.data;
      3'd5: m_tuser = {cmd.status, 1'b1};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) step <= 3'd7;
    else if (cmd_valid && m_tready) begin
      if (cur == fin_step) step <= 3'd7;
      else if (cur == 3'd3) step <= cmd.pay ? 3'd4 : 3'd5;
      else if (cur == 3'd4) step <= 3'd5;
      else step <= cur + 3'd1;
    end
  end
endmodule

// ----- test/testbench.sv -----
// Self-checking testbench of the length-prefixed to Annex B converter.
module testbench;
  import a2ab_pkg::*;

  typedef struct {
    logic [7:0]  data;
    logic        cfg;
    logic [23:0] size;
    logic        last;
  } in_word_t;

  typedef struct {
    logic       kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       run_last;
  } out_word_t;

  typedef enum logic [3:0] {
    PIdle, PSkip, PSLen, PSPay, PHArr, PHCntHi, PHCntLo, PHNalu,
    PASps, PAPpsCnt, PAPps, PCLenHi, PCLenLo, PCPay, PDone, PShort
  } parse_phase_t;

  localparam logic [0:0] AddrLayout = 1'b0;
  localparam int PosMax = 24'hFFFFFF;
  localparam int IdleLimit = 20000;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [0:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic s_tvalid = 0;
  logic s_tready;
  logic [31:0] s_tdata = '0;   // data_byte[7:0], buffer_size[31:8]
  logic s_tuser = 0;           // is_config
  logic s_tlast = 0;           // last_byte
  logic m_tvalid;
  logic m_tready = 0;
  logic [7:0] m_tdata;         // out_byte
  logic [2:0] m_tuser;         // kind[0], status[2:1]
  logic m_tlast;               // run_last

  avcc_to_annexb_converter_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // predictor state
  logic        hevc_layout;
  parse_phase_t ph;
  int unsigned pos, ulen, pay_left;
  logic [1:0]  pfx_cnt;
  logic [7:0]  grp_left;
  logic [15:0] units_left;
  logic        emitted;

  in_word_t  pending_words[$];
  out_word_t expected_words[$];
  int errors = 0;
  bit calm = 0;          // no idling in the final stretch
  int sent = 0;
  int idle_cycles = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void push_byte(input logic [7:0] b, input logic k,
                                    input logic [1:0] st);
    out_word_t w;
    w.kind = k; w.data = b; w.status = st; w.run_last = 0;
    expected_words.push_back(w);
  endfunction

  function automatic void push_start_code();
    push_byte(8'h00, 0, StOk); push_byte(8'h00, 0, StOk);
    push_byte(8'h00, 0, StOk); push_byte(8'h01, 0, StOk);
    emitted = 1;
  endfunction

  function automatic parse_phase_t after_list();
    if (hevc_layout) return PHNalu;
    return (grp_left != 0) ? PAPps : PASps;
  endfunction

  // walk one byte through the parser; may fall through several phases
  function automatic void parse_byte(input logic [7:0] b, input longint unsigned sz);
    longint unsigned p;
    int unsigned hdr;
    p = pos;
    forever begin
      case (ph)
        PSkip: begin
          hdr = hevc_layout ? 22 : 5;
          if (p < hdr) return;
          if (p > hdr) begin ph = PDone; return; end
          if (hevc_layout) begin
            grp_left = b; ph = PHArr;
          end else begin
            units_left = {11'd0, b[4:0]}; grp_left = 0; ph = PASps;
          end
          return;
        end
        PSLen: begin
          if (pfx_cnt == 0) begin
            if (p + 4 > sz) begin ph = PDone; return; end
            ulen = 0;
          end
          ulen = (ulen << 8) | b;
          pfx_cnt = pfx_cnt + 1;
          if (pfx_cnt == 0) begin
            if (ulen == 0 || p + 1 + ulen > sz) begin ph = PDone; return; end
            push_start_code();
            pay_left = ulen; ph = PSPay;
          end
          return;
        end
        PSPay: begin
          push_byte(b, 0, StOk);
          pay_left--;
          if (pay_left == 0) begin ph = PSLen; pfx_cnt = 0; end
          return;
        end
        PHArr: begin
          if (grp_left == 0 || p + 3 > sz) begin ph = PDone; return; end
          grp_left--; ph = PHCntHi; return;
        end
        PHCntHi: begin units_left = {b, 8'd0}; ph = PHCntLo; return; end
        PHCntLo: begin units_left = units_left | b; ph = PHNalu; return; end
        PHNalu: ph = (units_left > 0 && p + 2 <= sz) ? PCLenHi : PHArr;
        PASps: ph = (units_left > 0 && p + 2 <= sz) ? PCLenHi : PAPpsCnt;
        PAPpsCnt: begin
          if (p >= sz) begin ph = PDone; return; end
          units_left = b; grp_left = 1; ph = PAPps; return;
        end
        PAPps: begin
          ph = (units_left > 0 && p + 2 <= sz) ? PCLenHi : PDone;
          if (ph == PDone) return;
        end
        PCLenHi: begin ulen = b; ph = PCLenLo; return; end
        PCLenLo: begin
          ulen = ((ulen << 8) | b) & 16'hFFFF;
          if (p + 1 + ulen > sz) begin
            if (hevc_layout) ph = PHArr;
            else ph = (grp_left != 0) ? PDone : PAPpsCnt;
            return;
          end
          push_start_code();
          units_left--;
          if (ulen == 0) ph = after_list();
          else begin pay_left = ulen; ph = PCPay; end
          return;
        end
        PCPay: begin
          push_byte(b, 0, StOk);
          pay_left--;
          if (pay_left == 0) ph = after_list();
          return;
        end
        default: return;
      endcase
    end
  endfunction

  function automatic void clear_parser();
    ph = PIdle; pos = 0; ulen = 0; pay_left = 0; pfx_cnt = 0;
    grp_left = 0; units_left = 0; emitted = 0;
  endfunction

  // expected Annex B words for one accepted input word
  function automatic void predict_annexb(input in_word_t w);
    int n0;
    n0 = expected_words.size();
    if (ph == PIdle) begin
      pos = 0; emitted = 0; pfx_cnt = 0;
      if (!w.cfg) ph = (w.size < 4) ? PShort : PSLen;
      else ph = (w.size < (hevc_layout ? 23 : 7)) ? PShort : PSkip;
    end
    parse_byte(w.data, w.size);
    if (pos < PosMax) pos++;
    if (w.last) begin
      push_byte(8'h00, 1, (ph == PShort) ? StShort : (emitted ? StOk : StEmpty));
      clear_parser();
    end
    if (expected_words.size() > n0)
      expected_words[expected_words.size() - 1].run_last = 1;
  endfunction

  // ---------------- stimulus builders ----------------
  function automatic void add_word(input logic [7:0] b, input logic c,
                                   input int sz, input logic l);
    in_word_t w;
    w.data = b; w.cfg = c; w.size = sz[23:0]; w.last = l;
    pending_words.push_back(w);
  endfunction

  function automatic void add_buffer(input logic c, input int sz, input byte unsigned bytes[$]);
    foreach (bytes[i]) add_word(bytes[i], c, sz, i == bytes.size() - 1);
  endfunction

  // length-prefixed sample with random units; sometimes corrupted
  function automatic void add_sample();
    byte unsigned buf_q[$];
    int units, len, sz;
    units = $urandom_range(1, 3);
    for (int u = 0; u < units; u++) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      buf_q.push_back(0); buf_q.push_back(0); buf_q.push_back(0); buf_q.push_back(8'(len));
      for (int k = 0; k < len; k++) buf_q.push_back(8'($urandom));
    end
    sz = buf_q.size();
    case ($urandom_range(0, 7))
      0: sz = sz - $urandom_range(1, 3);
      1: sz = sz + $urandom_range(1, 3);
      2: buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom);
      3: void'(buf_q.pop_back());
      default: ;
    endcase
    add_buffer(0, sz, buf_q);
  endfunction

  function automatic void add_units(ref byte unsigned buf_q[$], input int count);
    int len;
    for (int u = 0; u < count; u++) begin
      len = $urandom_range(0, 3);
      buf_q.push_back(0); buf_q.push_back(8'(len));
      for (int k = 0; k < len; k++) buf_q.push_back(8'($urandom));
    end
  endfunction

  // avcC or hvcC record with random lists, following the current layout
  function automatic void add_record(input logic hevc);
    byte unsigned buf_q[$];
    int sz, n;
    if (!hevc) begin
      for (int k = 0; k < 5; k++) buf_q.push_back(8'($urandom));
      n = $urandom_range(0, 2);
      buf_q.push_back({3'($urandom), 5'(n)});
      add_units(buf_q, n);
      n = $urandom_range(0, 2);
      buf_q.push_back(8'(n));
      add_units(buf_q, n);
    end else begin
      for (int k = 0; k < 22; k++) buf_q.push_back(8'($urandom));
      n = $urandom_range(0, 2);
      buf_q.push_back(8'(n));
      for (int a = 0; a < n; a++) begin
        int c;
        c = $urandom_range(0, 2);
        buf_q.push_back(8'($urandom)); buf_q.push_back(0); buf_q.push_back(8'(c));
        add_units(buf_q, c);
      end
    end
    sz = buf_q.size();
    case ($urandom_range(0, 5))
      0: sz = sz - $urandom_range(1, 4);
      1: sz = sz + $urandom_range(1, 4);
      2: buf_q[$urandom_range(0, buf_q.size() - 1)] = 8'($urandom);
      default: ;
    endcase
    add_buffer(1, sz, buf_q);
  endfunction

  function automatic void add_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int k = 0; k < n; k++)
      add_word(8'($urandom), 1'($urandom), $urandom_range(0, 24'hFFFFFF), k == n - 1);
  endfunction

  // ---------------- driver ----------------
  int src_gap = 0, snk_gap = 0;
  in_word_t cur;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_annexb(cur);
        sent++;
      end
      if (!s_tvalid || s_tready) begin
        // pick the next word, or idle for a burst
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 15);
          s_tvalid <= 0;
        end else if (pending_words.size() > 0) begin
          cur = pending_words.pop_front();
          s_tvalid <= 1;
          s_tdata <= {cur.size, cur.data};
          s_tuser <= cur.cfg;
          s_tlast <= cur.last;
        end else begin
          s_tvalid <= 0;
        end
      end
      // receiver stalls
      if (snk_gap > 0) begin
        snk_gap--;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 15);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    out_word_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word data=%h user=%h", m_tdata, m_tuser));
      end else begin
        e = expected_words.pop_front();
        if (m_tuser[0] !== e.kind)
          report($sformatf("kind %b, want %b", m_tuser[0], e.kind));
        if (m_tdata !== e.data)
          report($sformatf("byte %h, want %h", m_tdata, e.data));
        if (m_tuser[2:1] !== e.status)
          report($sformatf("status %0d, want %0d", m_tuser[2:1], e.status));
        if (m_tlast !== e.run_last)
          report($sformatf("run_last %b, want %b", m_tlast, e.run_last));
      end
    end
  end

  // watchdog: cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  task automatic write_layout(input logic v);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= AddrLayout; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    hevc_layout = v;
  endtask

  // wait until the block has drained everything fed so far; look between edges
  // so the driver's updates of the same edge are already visible
  task automatic drain();
    @(negedge clk);
    while (pending_words.size() > 0 || s_tvalid || expected_words.size() > 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    byte unsigned q[$];
    hevc_layout = 0;
    clear_parser();
    repeat (7) @(posedge clk);
    rst <= 0;

    // directed sample cases: good unit, zero length, too short, extremes
    q = '{8'h00, 8'h00, 8'h00, 8'h02, 8'hFF, 8'h00};
    add_buffer(0, 6, q);
    q = '{8'h00, 8'h00, 8'h00, 8'h00};
    add_buffer(0, 4, q);
    q = '{8'hAA, 8'h55};
    add_buffer(0, 2, q);
    add_word(8'hFF, 1, 24'hFFFFFF, 1);
    add_word(8'h00, 0, 0, 1);
    q = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h11};
    add_buffer(0, 5, q);                  // overlong unit stops the parse
    q = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h11};
    add_buffer(0, 9, q);                  // last byte arrives early
    add_record(0);
    drain();

    write_layout(1);
    add_record(1);
    add_word(8'h01, 1, 22, 1);            // hvcC record too short
    drain();
    write_layout(0);
    add_word(8'h01, 1, 6, 1);             // avcC record too short
    drain();

    // random phases alternating the layout
    for (int phase_i = 0; phase_i < 6; phase_i++) begin
      write_layout(phase_i[0]);
      for (int k = 0; k < 1; k++) begin
        case ($urandom_range(0, 5))
          0, 1: add_sample();
          2, 3, 4: add_record(hevc_layout);
          default: add_noise();
        endcase
      end
      if (phase_i == 5) calm = 1;
      drain();
    end

    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/a2ab_pkg.sv
design/a2ab_parser.sv
design/a2ab_queue.sv
design/a2ab_emitter.sv
design/avcc_to_annexb_converter_core.sv
test/testbench.sv
